FILE: design/vfrn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfrn_pkg: shared types and binary32 helpers
// Float multiply and add, each rounded once to nearest even.
// ----------------------------------------------------------------------------
package vfrn_pkg;

    localparam logic [31:0] MAGIC_RSQRT = 32'h5f3759df;
    localparam logic [31:0] CANON_NAN   = 32'h7FC00000;
    localparam logic [31:0] F_HALF      = 32'h3F000000;
    localparam logic [31:0] F_THREE_HALF = 32'h3FC00000;

    localparam logic OP_NORM = 1'b0;
    localparam logic OP_COS  = 1'b1;

    // leading zero count of a 48-bit word
    function automatic logic [5:0] lzc48(input logic [47:0] x);
        logic [5:0] n;
        logic       found;
        n = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && x[i]) begin
                n = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // round and pack: sign, exponent (biased, signed wide), 27-bit mantissa
    // with hidden bit at [26], guard/round/sticky in [2:0]
    function automatic logic [31:0] fpack(input logic s, input logic signed [10:0] e,
                                          input logic [26:0] m);
        logic [26:0]        mm;
        logic [4:0]         sh;
        logic               st;
        logic [24:0]        r;
        logic signed [10:0] ee;
        ee = e;
        mm = m;
        if (ee < 11'sd1) begin
            sh = (ee < -11'sd26) ? 5'd27 : 5'(11'sd1 - ee);
            st = 1'b0;
            for (int i = 0; i < 27; i++)
                if (i < int'(sh) && mm[i]) st = 1'b1;
            mm = (sh >= 5'd27) ? 27'd0 : (mm >> sh);
            mm[0] = mm[0] | st;
            ee = 11'sd0;
        end
        r = {1'b0, mm[26:3]};
        if (mm[2] && (mm[1] || mm[0] || mm[3])) r = r + 25'd1;
        if (r[24]) begin
            r = r >> 1;
            ee = ee + 11'sd1;
        end
        if (ee == 11'sd0 && r[23]) ee = 11'sd1;
        if (ee >= 11'sd255) return {s, 8'hFF, 23'd0};
        return {s, ee[7:0], r[22:0]};
    endfunction

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic [23:0]        ma, mb;
        logic [47:0]        p;
        logic signed [10:0] e;
        logic [5:0]         lz;
        logic [47:0]        n;
        logic               ainf, binf, az, bz;
        s = a[31] ^ b[31];
        ainf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        binf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        az = (a[30:0] == 31'd0);
        bz = (b[30:0] == 31'd0);
        if (is_nan(a) || is_nan(b) || (ainf && bz) || (binf && az)) return CANON_NAN;
        if (ainf || binf) return {s, 8'hFF, 23'd0};
        if (az || bz) return {s, 31'd0};
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        p = ma * mb;
        e = 11'($signed({3'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]}))
          + 11'($signed({3'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]})) - 11'sd126;
        lz = lzc48(p);
        n = p << lz;
        e = e - 11'($signed({5'd0, lz}));
        return fpack(s, e, {n[47:22], (n[21:0] != 22'd0)});
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]        x, y;
        logic [7:0]         ex, ey;
        logic [7:0]         d;
        logic [49:0]        mx, my, sum;
        logic               st;
        logic [5:0]         lz;
        logic [47:0]        n;
        logic signed [10:0] e;
        logic               xinf, yinf;
        xinf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        yinf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (xinf && yinf) return (a[31] == b[31]) ? a : CANON_NAN;
        if (xinf) return a;
        if (yinf) return b;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
        if (a[30:0] >= b[30:0]) begin x = a; y = b; end
        else begin x = b; y = a; end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d = ex - ey;
        mx = {1'b0, (x[30:23] != 8'd0), x[22:0], 25'd0};
        my = {1'b0, (y[30:23] != 8'd0), y[22:0], 25'd0};
        st = 1'b0;
        if (d > 8'd40) begin
            st = (my != 50'd0);
            my = 50'd0;
        end else begin
            for (int i = 0; i < 50; i++)
                if (i < int'(d) && my[i]) st = 1'b1;
            my = my >> d;
        end
        my[0] = my[0] | st;
        sum = (x[31] == y[31]) ? (mx + my) : (mx - my);
        if (sum == 50'd0) return 32'd0;
        e = 11'($signed({3'd0, ex})) + 11'sd1;
        lz = lzc48(sum[49:2]);
        if (lz == 6'd48) begin
            n = {sum[1:0], 46'd0};
            e = e - 11'sd48;
        end else begin
            n = sum[49:2] << lz;
            if (lz != 6'd0) n[lz-1] = sum[1];
            e = e - 11'($signed({5'd0, lz}));
        end
        return fpack(x[31], e, {n[47:22], (n[21:0] != 22'd0) | sum[0] | (lz == 0 && sum[1])});
    endfunction

    function automatic logic [31:0] canon(input logic [31:0] a);
        return is_nan(a) ? CANON_NAN : a;
    endfunction

endpackage

FILE: design/vec2_fast_rsqrt_normalize_cosine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec2_fast_rsqrt_normalize_cosine_top: pipelined 2D normalize / cosine
// Fast inverse square root with one Newton step, binary32 datapath.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis words carry {b_y, b_x, a_y, a_x} in tdata and the opcode in tuser.
//   Opcode 0 normalizes a; opcode 1 gives cos(a,b) in out_x, 0 in out_y.
//   m_axis words carry {out_y, out_x} in tdata.
// Throughput: one word per cycle while the output is not stalled. Nine
//   register stages, the first loaded at accept, follow the chain of
//   dependent float ops (squares, sums, product, estimate, two Newton
//   products, subtract, Newton product, final product), one per stage.
// Stall: the pipeline advances as a whole when the output register is free
//   or being taken; s_tready drops only while the full output word waits.
// Reset (aresetn low, synchronous) clears all valid bits; data registers are
//   not reset.
// ----------------------------------------------------------------------------
module vec2_fast_rsqrt_normalize_cosine_top
    import vfrn_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_x, a_y, b_x, b_y
    input  logic         s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // out_x, out_y
);

    localparam int NS = 9;

    typedef struct packed {
        logic        op;
        logic [31:0] ax, ay;
        logic [31:0] p0, p1, p2, p3; // working values per stage
    } stg_t;

    stg_t       st_reg [NS];
    stg_t       st_next [NS];
    logic [NS-1:0] vld_reg;
    logic        adv;

    // cosine dot product is formed alongside the squares and carried in ax
    logic [31:0] dot_s1_next;
    logic [31:0] dxy0_reg, dxy1_reg;

    // whole pipe moves unless the final word is stalled
    assign adv      = !(vld_reg[NS-1] && !m_tready);
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {st_reg[NS-1].p1, st_reg[NS-1].p0};

    always_ff @(posedge aclk) begin
        if (adv) begin
            dxy0_reg <= fmul(s_tdata[31:0], s_tdata[95:64]);
            dxy1_reg <= fmul(s_tdata[63:32], s_tdata[127:96]);
        end
    end
    assign dot_s1_next = fadd(dxy0_reg, dxy1_reg);

    always_comb begin
        stg_t c;
        logic [31:0] vb;
        // s0: squares and cross products
        c.op = s_tuser;
        c.ax = s_tdata[31:0];
        c.ay = s_tdata[63:32];
        c.p0 = fmul(s_tdata[31:0], s_tdata[31:0]);
        c.p1 = fmul(s_tdata[63:32], s_tdata[63:32]);
        c.p2 = fmul(s_tdata[95:64], s_tdata[95:64]);
        c.p3 = fmul(s_tdata[127:96], s_tdata[127:96]);
        st_next[0] = c;
        // s1: sums; stash the dot product in the ax slot for cosine
        c = st_reg[0];
        c.p0 = fadd(st_reg[0].p0, st_reg[0].p1);
        c.p1 = fadd(st_reg[0].p2, st_reg[0].p3);
        if (st_reg[0].op == OP_COS) c.ax = dot_s1_next;
        st_next[1] = c;
        // s2: v
        c = st_reg[1];
        c.p0 = (st_reg[1].op == OP_COS) ? fmul(st_reg[1].p0, st_reg[1].p1) : st_reg[1].p0;
        st_next[2] = c;
        // s3: estimate and half v
        c = st_reg[2];
        vb = st_reg[2].p0;
        c.p1 = MAGIC_RSQRT - {1'b0, vb[31:1]};
        c.p0 = fmul(F_HALF, vb);
        st_next[3] = c;
        // s4: t = h*w
        c = st_reg[3];
        c.p0 = fmul(st_reg[3].p0, st_reg[3].p1);
        st_next[4] = c;
        // s5: t = t*w
        c = st_reg[4];
        c.p0 = fmul(st_reg[4].p0, st_reg[4].p1);
        st_next[5] = c;
        // s6: k = 1.5 - t
        c = st_reg[5];
        c.p0 = fadd(F_THREE_HALF, {~st_reg[5].p0[31], st_reg[5].p0[30:0]});
        st_next[6] = c;
        // s7: w = w*k
        c = st_reg[6];
        c.p1 = fmul(st_reg[6].p1, st_reg[6].p0);
        st_next[7] = c;
        // s8: outputs
        c = st_reg[7];
        if (st_reg[7].op == OP_COS) begin
            c.p0 = canon(fmul(st_reg[7].ax, st_reg[7].p1));
            c.p1 = 32'd0;
        end else begin
            c.p0 = canon(fmul(st_reg[7].ax, st_reg[7].p1));
            c.p1 = canon(fmul(st_reg[7].ay, st_reg[7].p1));
        end
        st_next[8] = c;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NS; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
        end
    end

    // a stalled result word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");
    // cosine results always carry a zero y
    a_cos_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st_reg[NS-1].op == OP_COS |-> m_tdata[63:32] == 32'd0)
        else $error("cosine out_y not zero");
    // an accepted word is captured in the first stage
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word not captured");

endmodule

FILE: bench/vfrn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfrn_checker: scoreboard for the 2D normalize / cosine unit
// Watches both stream channels, computes each expected result word with an
// independent binary32 model and compares it with the output words in order.
// ----------------------------------------------------------------------------
module vfrn_checker
    import vfrn_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    output int           n_errors,
    output int           n_pending
);

    logic [63:0] vec_result_q[$];

    function automatic logic f_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic f_inf(input logic [31:0] a);
        return (a[30:0] == 31'h7F80_0000);
    endfunction

    // m normalized with leading one at bit 63, value 1.f * 2^e2
    function automatic logic [31:0] f32_round(input logic s, input int e2,
                                              input logic [63:0] m);
        logic [127:0] q;
        logic [24:0]  kept;
        int           be;
        int           sh;
        be = e2 + 127;
        sh = (be >= 1) ? 40 : 41 - be;
        if (sh > 120) sh = 120;
        q = {m, 64'd0} >> sh;
        kept = q[88:64];
        if (q[63] && ((|q[62:0]) || kept[0])) kept = kept + 25'd1;
        if (be >= 1) begin
            if (kept[24]) begin
                kept = kept >> 1;
                be++;
            end
            if (be >= 255) return {s, 8'hFF, 23'd0};
            return {s, 8'(be), kept[22:0]};
        end
        return {s, 7'd0, kept[23], kept[22:0]};
    endfunction

    function automatic int f_exp(input logic [31:0] a);
        return ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 127;
    endfunction

    function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic [47:0] p;
        logic [63:0] m;
        int          e2;
        s = a[31] ^ b[31];
        if (f_nan(a) || f_nan(b)) return CANON_NAN;
        if ((f_inf(a) && b[30:0] == 0) || (f_inf(b) && a[30:0] == 0)) return CANON_NAN;
        if (f_inf(a) || f_inf(b)) return {s, 8'hFF, 23'd0};
        if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
        p = {a[30:23] != 0, a[22:0]} * {b[30:23] != 0, b[22:0]};
        m = {p, 16'd0};
        e2 = f_exp(a) + f_exp(b) + 1;
        while (!m[63]) begin
            m = m << 1;
            e2--;
        end
        return f32_round(s, e2, m);
    endfunction

    function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y;
        logic [63:0] mx, my, m;
        int          d;
        int          e2;
        if (f_nan(a) || f_nan(b)) return CANON_NAN;
        if (f_inf(a) && f_inf(b)) return (a[31] == b[31]) ? a : CANON_NAN;
        if (f_inf(a)) return a;
        if (f_inf(b)) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
        if (a[30:0] == 0) return b;
        if (b[30:0] == 0) return a;
        if (a[30:0] >= b[30:0]) begin
            x = a; y = b;
        end else begin
            x = b; y = a;
        end
        d = f_exp(x) - f_exp(y);
        mx = 64'({x[30:23] != 0, x[22:0]}) << 38;
        my = 64'({y[30:23] != 0, y[22:0]}) << 38;
        if (d > 40) my = 64'd1;
        else if (d > 0) my = (my >> d) | 64'(|(my & ((64'd1 << d) - 1)));
        m = (x[31] == y[31]) ? mx + my : mx - my;
        if (m == 0) return 32'd0;
        e2 = f_exp(x) + 2;
        while (!m[63]) begin
            m = m << 1;
            e2--;
        end
        return f32_round(x[31], e2, m);
    endfunction

    function automatic logic [31:0] inv_sqrt_step(input logic [31:0] v);
        logic [31:0] w, t;
        w = MAGIC_RSQRT - (v >> 1);
        t = f32_mul(f32_mul(f32_mul(F_HALF, v), w), w);
        return f32_mul(w, f32_add(F_THREE_HALF, {~t[31], t[30:0]}));
    endfunction

    function automatic logic [31:0] nan_fix(input logic [31:0] a);
        return f_nan(a) ? CANON_NAN : a;
    endfunction

    function automatic logic [63:0] vec_predict(input logic op, input logic [127:0] d);
        logic [31:0] ax, ay, bx, by, v, w, dot;
        ax = d[31:0];
        ay = d[63:32];
        bx = d[95:64];
        by = d[127:96];
        v = f32_add(f32_mul(ax, ax), f32_mul(ay, ay));
        if (op == OP_NORM) begin
            w = inv_sqrt_step(v);
            return {nan_fix(f32_mul(ay, w)), nan_fix(f32_mul(ax, w))};
        end
        v = f32_mul(v, f32_add(f32_mul(bx, bx), f32_mul(by, by)));
        w = inv_sqrt_step(v);
        dot = f32_add(f32_mul(ax, bx), f32_mul(ay, by));
        return {32'd0, nan_fix(f32_mul(dot, w))};
    endfunction

    always @(posedge aclk) begin
        logic [63:0] exp_w;
        if (!aresetn) begin
            n_errors = 0;
        end else begin
            if (s_tvalid && s_tready) vec_result_q.push_back(vec_predict(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (vec_result_q.size() == 0) begin
                    $error("unexpected output word %h", m_tdata);
                    n_errors++;
                end else begin
                    exp_w = vec_result_q.pop_front();
                    if (m_tdata[31:0] !== exp_w[31:0]) begin
                        $error("out_x expected %h actual %h", exp_w[31:0], m_tdata[31:0]);
                        n_errors++;
                    end
                    if (m_tdata[63:32] !== exp_w[63:32]) begin
                        $error("out_y expected %h actual %h", exp_w[63:32], m_tdata[63:32]);
                        n_errors++;
                    end
                end
            end
        end
        n_pending = vec_result_q.size();
    end

endmodule

FILE: bench/vec2_fast_rsqrt_normalize_cosine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec2_fast_rsqrt_normalize_cosine_top_tb: stream test of the 2D vector unit
// Directed special values, then random vectors in four flow-control phases;
// the checker module scores every output word.
// ----------------------------------------------------------------------------
module vec2_fast_rsqrt_normalize_cosine_top_tb
    import vfrn_pkg::*;
();

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // a_x, a_y, b_x, b_y
    logic         s_tuser;   // opcode
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // out_x, out_y
    int           n_errors;
    int           n_pending;
    int           src_idle_pct;
    int           sink_stall_pct;

    vec2_fast_rsqrt_normalize_cosine_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    vfrn_checker i_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .n_errors(n_errors), .n_pending(n_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver backpressure, rate set per phase
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // random binary32 operand: mostly ordinary magnitudes, some raw bits and specials
    function automatic logic [31:0] rand_f32();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(9))
            0: return r;
            1: begin
                case ($urandom_range(5))
                    0: return {r[31], 31'd0};
                    1: return {r[31], 8'hFF, 23'd0};
                    2: return {r[31], 8'hFF, r[22:0] | 23'd1};
                    3: return {r[31], 8'd0, r[22:0]};
                    4: return {r[31], 8'hFE, r[22:0]};
                    default: return {r[31], 8'(r[24] ? 1 : 8'h40 + r[26:25]), r[22:0]};
                endcase
            end
            2: return {r[31], 8'($urandom_range(70, 190)), r[22:0]};
            default: return {r[31], 8'($urandom_range(110, 145)), r[22:0]};
        endcase
    endfunction

    // one word on the input channel; a random gap may follow it
    task automatic send_vec(input logic op, input logic [31:0] ax, input logic [31:0] ay,
                            input logic [31:0] bx, input logic [31:0] by);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {by, bx, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct) @(posedge aclk);
        end
    endtask

    // hold the input quiet until every predicted word has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] spec[12];
        s_tvalid = 1'b0;
        s_tuser = OP_NORM;
        s_tdata = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zeros, infinities, NaN, subnormals, extremes, ordinary values
        spec = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                 32'hFFFF_FFFF, 32'h3F80_0000, 32'hC040_0000, 32'h3F00_0000};
        for (int i = 0; i < 12; i++)
            send_vec(OP_NORM, spec[i], spec[(i + 9) % 12], spec[(i + 3) % 12], spec[i]);
        for (int i = 0; i < 12; i++)
            send_vec(OP_COS, spec[(i + 9) % 12], spec[i], spec[i], spec[(i + 5) % 12]);
        send_vec(OP_COS, 32'h3F80_0000, 32'h4000_0000, 32'h0000_0000, 32'h8000_0000);
        drain();

        // random phases: free flow, idle sender, stalling receiver, both lightly
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = (ph == 1) ? 53 : (ph == 3) ? 7 : 0;
            sink_stall_pct = (ph == 2) ? 53 : (ph == 3) ? 7 : 0;
            for (int n = 0; n < 190; n++)
                send_vec(1'($urandom_range(1)), rand_f32(), rand_f32(), rand_f32(), rand_f32());
            drain();
        end

        repeat (20) @(posedge aclk);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
